[hw/rtl/readout_word_hit_decoder_unit_macros.svh]
// ---------------------------------------------------------------------------
// Readout word hit decoder assertion macros
// Concurrent assertion wrappers, clocked on aclk; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef READOUT_WORD_HIT_DECODER_UNIT_MACROS_SVH
`define READOUT_WORD_HIT_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define RWHD_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("rwhd assertion failed");

// checked on every edge, reset included
`define RWHD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("rwhd assertion failed");

`else

`define RWHD_ASSERT(label, prop)
`define RWHD_ASSERT_ALWAYS(label, prop)

`endif

`endif

[hw/rtl/rwhd_pkg.sv]
// ---------------------------------------------------------------------------
// rwhd_pkg
// Types and constants shared by the readout word hit decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rwhd_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned TDATA_W   = 136;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 4;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GOOD_FRONTEND = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GOOD_MODULE   = 1'd1;

    localparam logic [3:0] GOOD_FRONTEND_RST = 4'd4;
    localparam logic [3:0] GOOD_MODULE_RST   = 4'd7;

    localparam logic [15:0] TAG_EVENT    = 16'h0001;
    localparam logic [15:0] TAG_CROSSING = 16'h0002;

    localparam logic [5:0] CHIP_FOLD_AT   = 6'd27;
    localparam logic [5:0] CHIP_FOLD_SUB  = 6'd26;
    localparam logic [5:0] CHIP_MAX_GOOD  = 6'd26;
    localparam logic [6:0] CHAN_MAX_GOOD  = 7'd126;

    // front-end ids with a module mapping
    localparam logic [3:0] FE_A = 4'd1;
    localparam logic [3:0] FE_B = 4'd2;
    localparam logic [3:0] FE_C = 4'd4;
    localparam logic [3:0] FE_D = 4'd8;

    typedef enum logic [1:0] {
        KIND_EVENT,
        KIND_CROSSING,
        KIND_FRONTEND,
        KIND_HIT
    } word_kind_t;

    typedef struct packed {
        word_kind_t  kind;
        logic [15:0] high_half;
        logic [3:0]  frontend_id;
        logic [2:0]  adc;
        logic [6:0]  amplitude;
        logic [5:0]  chip;
        logic [3:0]  module_no;
        logic [6:0]  channel;
        logic [6:0]  crossing;
        logic        noise;
    } dec_t;

    // result item layout, lowest field last
    typedef struct packed {
        logic        pad;
        logic [31:0] noise_total;
        logic        noise;
        logic [31:0] hit_index;
        logic [15:0] event_number;
        logic [15:0] crossing_full;
        logic [6:0]  crossing;
        logic [3:0]  frontend;
        logic [6:0]  channel;
        logic [3:0]  module_no;
        logic [5:0]  chip;
        logic [6:0]  amplitude;
        logic [2:0]  adc;
    } hit_t;

endpackage

[hw/rtl/readout_word_hit_decoder_unit.sv]
// A hit word is held in the input register, decoded, then held in the result register.
// Throughput: one word per cycle unless m_tready stalls; context words update state only.
// Reset (aresetn low, synchronous): context, counters and both valids cleared;
// good_frontend returns to 4 and good_module to 7.
// ---------------------------------------------------------------------------
// readout_word_hit_decoder_unit
// Sorts readout words into context updates and hits, emitting each hit with
// its context, running hit index and noise bookkeeping.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "readout_word_hit_decoder_unit_macros.svh"

module readout_word_hit_decoder_unit
    import rwhd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [WORD_W-1:0]     s_tdata,   // word[31:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // adc[2:0] amplitude[9:3] chip[15:10] module_no[19:16] channel[26:20]
    // frontend[30:27] crossing[37:31] crossing_full[53:38] event_number[69:54]
    // hit_index[101:70] noise[102] noise_total[134:103] zero[135]
    output logic [TDATA_W-1:0]    m_tdata
);

    logic              in_valid_reg, in_valid_next;
    logic [WORD_W-1:0] in_word_reg;
    logic              out_valid_reg, out_valid_next;
    hit_t              out_reg;
    hit_t              hit;

    logic [15:0] event_reg, event_next;
    logic [15:0] xfull_reg, xfull_next;
    logic [3:0]  frontend_reg, frontend_next;
    logic [3:0]  module_reg, module_next;
    logic [31:0] hit_cnt_reg, hit_cnt_next;
    logic [31:0] noise_cnt_reg, noise_cnt_next;
    logic [3:0]  good_fe_reg, good_fe_next;
    logic [3:0]  good_mod_reg, good_mod_next;

    logic advance;
    logic process;
    logic out_load;
    dec_t dec;

    rwhd_decode u_decode (
        .word          (in_word_reg),
        .frontend_cur  (frontend_reg),
        .module_cur    (module_reg),
        .good_frontend (good_fe_reg),
        .good_module   (good_mod_reg),
        .dec           (dec)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign out_load = process && (dec.kind == KIND_HIT);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? out_load : out_valid_reg;

        event_next     = event_reg;
        xfull_next     = xfull_reg;
        frontend_next  = frontend_reg;
        module_next    = module_reg;
        hit_cnt_next   = hit_cnt_reg;
        noise_cnt_next = noise_cnt_reg;
        if (process) begin
            unique case (dec.kind)
                KIND_EVENT:    event_next    = dec.high_half;
                KIND_CROSSING: xfull_next    = dec.high_half;
                KIND_FRONTEND: frontend_next = dec.frontend_id;
                KIND_HIT: begin
                    module_next    = dec.module_no;
                    hit_cnt_next   = hit_cnt_reg + 32'd1;
                    noise_cnt_next = noise_cnt_reg + {31'd0, dec.noise};
                end
                default: ;
            endcase
        end

        good_fe_next  = good_fe_reg;
        good_mod_next = good_mod_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_GOOD_FRONTEND: good_fe_next  = cfg_wdata;
                REG_GOOD_MODULE:   good_mod_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        hit.pad           = 1'b0;
        hit.noise_total   = noise_cnt_next;
        hit.noise         = dec.noise;
        hit.hit_index     = hit_cnt_reg;
        hit.event_number  = event_reg;
        hit.crossing_full = xfull_reg;
        hit.crossing      = dec.crossing;
        hit.frontend      = frontend_reg;
        hit.channel       = dec.channel;
        hit.module_no     = dec.module_no;
        hit.chip          = dec.chip;
        hit.amplitude     = dec.amplitude;
        hit.adc           = dec.adc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            event_reg     <= '0;
            xfull_reg     <= '0;
            frontend_reg  <= '0;
            module_reg    <= '0;
            hit_cnt_reg   <= '0;
            noise_cnt_reg <= '0;
            good_fe_reg   <= GOOD_FRONTEND_RST;
            good_mod_reg  <= GOOD_MODULE_RST;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            event_reg     <= event_next;
            xfull_reg     <= xfull_next;
            frontend_reg  <= frontend_next;
            module_reg    <= module_next;
            hit_cnt_reg   <= hit_cnt_next;
            noise_cnt_reg <= noise_cnt_next;
            good_fe_reg   <= good_fe_next;
            good_mod_reg  <= good_mod_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_word_reg <= s_tdata;
        end
        if (out_load) begin
            out_reg <= hit;
        end
    end

    `RWHD_ASSERT(a_hit_cnt_step, out_load |=> hit_cnt_reg == 32'($past(hit_cnt_reg) + 32'd1))
    `RWHD_ASSERT(a_hit_cnt_hold, !out_load |=> $stable(hit_cnt_reg))
    `RWHD_ASSERT(a_noise_step, (out_load && dec.noise) |=> noise_cnt_reg == $past(noise_cnt_reg) + 32'd1)
    `RWHD_ASSERT(a_index_tracks, out_valid_reg |-> 32'(out_reg.hit_index + 32'd1) == hit_cnt_reg)
    `RWHD_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_reg |-> s_tready)

endmodule

[hw/rtl/rwhd_decode.sv]
// ---------------------------------------------------------------------------
// rwhd_decode
// Classifies one readout word and unpacks a hit with module lookup and
// health cuts against the current context.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwhd_decode
    import rwhd_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  logic [3:0]        frontend_cur,
    input  logic [3:0]        module_cur,
    input  logic [3:0]        good_frontend,
    input  logic [3:0]        good_module,
    output dec_t              dec
);

    logic [5:0] raw_chip;
    logic       upper;
    logic [3:0] module_new;

    assign raw_chip = word[8:3];
    assign upper    = raw_chip >= CHIP_FOLD_AT;

    always_comb begin
        module_new = module_cur;
        unique case (frontend_cur)
            FE_A:    module_new = upper ? 4'd2 : 4'd1;
            FE_B:    module_new = upper ? 4'd4 : 4'd3;
            FE_C:    module_new = upper ? 4'd8 : 4'd7;
            FE_D:    module_new = upper ? 4'd6 : 4'd5;
            default: module_new = module_cur;
        endcase
    end

    always_comb begin
        priority if (word[15:0] == TAG_EVENT) begin
            dec.kind = KIND_EVENT;
        end else if (word[15:0] == TAG_CROSSING) begin
            dec.kind = KIND_CROSSING;
        end else if (word[11:0] == 12'd0) begin
            dec.kind = KIND_FRONTEND;
        end else begin
            dec.kind = KIND_HIT;
        end
        dec.high_half   = word[31:16];
        dec.frontend_id = word[15:12];
        dec.adc         = word[2:0];
        dec.amplitude   = word[30:24];
        dec.chip        = upper ? raw_chip - CHIP_FOLD_SUB : raw_chip;
        dec.module_no   = module_new;
        dec.channel     = word[15:9];
        dec.crossing    = word[22:16];
        dec.noise       = (dec.amplitude != 7'd0)
                       || (dec.chip == 6'd0) || (dec.chip > CHIP_MAX_GOOD)
                       || (dec.channel == 7'd0) || (dec.channel > CHAN_MAX_GOOD)
                       || (frontend_cur != good_frontend)
                       || (module_new != good_module);
    end

endmodule

[test/readout_word_hit_decoder_unit_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// readout_word_hit_decoder_unit_test
// Streams readout words into the decoder and checks every hit item against
// a cycle-free predictor of the context, module lookup and noise bookkeeping.
// A directed set of edge cases runs first, then random word streams under
// several health settings, random idling on both sides and a long output hold.
// ---------------------------------------------------------------------------

module readout_word_hit_decoder_unit_test
    import rwhd_pkg::*;
();

    class hit_scoreboard;
        logic [3:0]  good_fe;
        logic [3:0]  good_mod;
        logic [15:0] event_no;
        logic [15:0] xing_full;
        logic [3:0]  fe_id;
        logic [3:0]  module_id;
        logic [31:0] hit_count;
        logic [31:0] noise_count;
        hit_t        expected_hits[$];
        int          errors;
        int          words_seen;
        int          hits_checked;
        int          noisy_seen;

        function new();
            good_fe      = GOOD_FRONTEND_RST;
            good_mod     = GOOD_MODULE_RST;
            event_no     = '0;
            xing_full    = '0;
            fe_id        = '0;
            module_id    = '0;
            hit_count    = '0;
            noise_count  = '0;
            errors       = 0;
            words_seen   = 0;
            hits_checked = 0;
            noisy_seen   = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] val);
            if (addr == REG_GOOD_FRONTEND) begin
                good_fe = val;
            end else if (addr == REG_GOOD_MODULE) begin
                good_mod = val;
            end
        endfunction

        function void note_word(logic [31:0] w);
            hit_t       h;
            logic [5:0] raw_chip;
            logic       upper;
            words_seen++;
            if (w[15:0] == TAG_EVENT) begin
                event_no = w[31:16];
            end else if (w[15:0] == TAG_CROSSING) begin
                xing_full = w[31:16];
            end else if (w[11:0] == 12'd0) begin
                fe_id = w[15:12];
            end else begin
                raw_chip = w[8:3];
                upper    = raw_chip >= CHIP_FOLD_AT;
                case (fe_id)
                    FE_A: module_id = upper ? 4'd2 : 4'd1;
                    FE_B: module_id = upper ? 4'd4 : 4'd3;
                    FE_C: module_id = upper ? 4'd8 : 4'd7;
                    FE_D: module_id = upper ? 4'd6 : 4'd5;
                    default: ;
                endcase
                h               = '0;
                h.adc           = w[2:0];
                h.amplitude     = w[30:24];
                h.chip          = upper ? raw_chip - CHIP_FOLD_SUB : raw_chip;
                h.module_no     = module_id;
                h.channel       = w[15:9];
                h.frontend      = fe_id;
                h.crossing      = w[22:16];
                h.crossing_full = xing_full;
                h.event_number  = event_no;
                h.hit_index     = hit_count;
                h.noise = (h.amplitude != 0) || (h.chip == 0) || (h.chip > CHIP_MAX_GOOD)
                    || (h.channel == 0) || (h.channel > CHAN_MAX_GOOD)
                    || (fe_id != good_fe) || (module_id != good_mod);
                if (h.noise) begin
                    noise_count++;
                end
                h.noise_total = noise_count;
                hit_count++;
                expected_hits.push_back(h);
            end
        endfunction

        function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_hit(logic [TDATA_W-1:0] d);
            hit_t got;
            hit_t exp_h;
            got = d;
            if (expected_hits.size() == 0) begin
                errors++;
                $display("%0t: unexpected hit item, expected none, got %h", $time, d);
                return;
            end
            exp_h = expected_hits.pop_front();
            hits_checked++;
            if (exp_h.noise) begin
                noisy_seen++;
            end
            cmp_field("pad", 32'(exp_h.pad), 32'(got.pad));
            cmp_field("adc", 32'(exp_h.adc), 32'(got.adc));
            cmp_field("amplitude", 32'(exp_h.amplitude), 32'(got.amplitude));
            cmp_field("chip", 32'(exp_h.chip), 32'(got.chip));
            cmp_field("module_no", 32'(exp_h.module_no), 32'(got.module_no));
            cmp_field("channel", 32'(exp_h.channel), 32'(got.channel));
            cmp_field("frontend", 32'(exp_h.frontend), 32'(got.frontend));
            cmp_field("crossing", 32'(exp_h.crossing), 32'(got.crossing));
            cmp_field("crossing_full", 32'(exp_h.crossing_full), 32'(got.crossing_full));
            cmp_field("event_number", 32'(exp_h.event_number), 32'(got.event_number));
            cmp_field("hit_index", exp_h.hit_index, got.hit_index);
            cmp_field("noise", 32'(exp_h.noise), 32'(got.noise));
            cmp_field("noise_total", exp_h.noise_total, got.noise_total);
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_LEN    = 80;
    localparam int SETTLE      = 6;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [WORD_W-1:0]     s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_W-1:0]    m_tdata;

    hit_scoreboard sb;
    int            send_idle;
    int            recv_idle;
    int            hold_req;
    int            hold_left;
    int            cycle_count;
    int            settings_run;

    readout_word_hit_decoder_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random idling plus a long hold when requested
    always @(negedge aclk) begin
        if (hold_req != 0) begin
            hold_left = HOLD_LEN;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(99) >= recv_idle;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_hit(m_tdata);
        end
    end

    function automatic logic [31:0] hit_word(logic [6:0] amp, logic [6:0] xing,
                                             logic [6:0] chan, logic [5:0] chip,
                                             logic [2:0] adc);
        return {1'b0, amp, 1'b0, xing, chan, chip, adc};
    endfunction

    function automatic logic [31:0] random_word();
        int         pick;
        logic [3:0] fe;
        logic [5:0] chip;
        logic [6:0] chan;
        logic [6:0] amp;
        logic [31:0] w;
        pick = $urandom_range(99);
        w    = $urandom();
        if (pick < 8) begin
            w[15:0] = TAG_EVENT;
        end else if (pick < 16) begin
            w[15:0] = TAG_CROSSING;
        end else if (pick < 26) begin
            case ($urandom_range(5))
                0: fe = FE_A;
                1: fe = FE_B;
                2: fe = FE_C;
                3: fe = FE_D;
                default: fe = 4'($urandom_range(15));
            endcase
            w[15:12] = fe;
            w[11:0]  = 12'd0;
        end else if (pick < 88) begin
            amp  = ($urandom_range(7) == 0) ? 7'($urandom_range(127)) : 7'd0;
            chip = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                            : 6'($urandom_range(52, 1));
            chan = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                            : 7'($urandom_range(126, 1));
            w[30:24] = amp;
            w[15:9]  = chan;
            w[8:3]   = chip;
        end
        return w;
    endfunction

    task automatic send_word(input logic [31:0] w);
        @(negedge aclk);
        if ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            do @(negedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(w);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.set_reg(addr, val);
    endtask

    task automatic set_health(input logic [3:0] fe, input logic [3:0] md);
        cfg_write(REG_GOOD_FRONTEND, fe);
        cfg_write(REG_GOOD_MODULE, md);
        settings_run++;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_word(random_word());
    endtask

    task automatic run_directed();
        logic [31:0] words[$];
        words.push_back(hit_word(7'd0, 7'd5, 7'd10, 6'd5, 3'd3));   // no context yet
        words.push_back(32'hFFFF_0001);
        words.push_back(32'hABCD_0002);
        words.push_back(32'h0000_4000);
        words.push_back(hit_word(7'd0, 7'd127, 7'd1, 6'd1, 3'd0));
        words.push_back(hit_word(7'd0, 7'd0, 7'd126, 6'd26, 3'd7));
        words.push_back(hit_word(7'd0, 7'd3, 7'd20, 6'd27, 3'd1));  // upper half
        words.push_back(hit_word(7'd0, 7'd3, 7'd20, 6'd52, 3'd1));
        words.push_back(hit_word(7'd0, 7'd3, 7'd20, 6'd63, 3'd1));
        words.push_back(hit_word(7'd0, 7'd3, 7'd20, 6'd0, 3'd1));
        words.push_back(hit_word(7'd0, 7'd3, 7'd0, 6'd5, 3'd1));
        words.push_back(hit_word(7'd0, 7'd3, 7'd127, 6'd5, 3'd1));
        words.push_back(hit_word(7'd127, 7'd3, 7'd20, 6'd5, 3'd1));
        words.push_back(32'hFFFF_FFFF);
        words.push_back(32'h0000_1000);
        words.push_back(hit_word(7'd0, 7'd9, 7'd30, 6'd4, 3'd2));
        words.push_back(hit_word(7'd0, 7'd9, 7'd30, 6'd40, 3'd2));
        words.push_back(32'h0000_2000);
        words.push_back(hit_word(7'd0, 7'd9, 7'd30, 6'd40, 3'd2));
        words.push_back(32'h0000_8000);
        words.push_back(hit_word(7'd0, 7'd9, 7'd30, 6'd4, 3'd2));
        words.push_back(32'h0000_3000);                              // unmapped id
        words.push_back(hit_word(7'd0, 7'd9, 7'd30, 6'd40, 3'd2));
        words.push_back(32'h0000_0000);
        words.push_back(32'hFFFF_F000);
        words.push_back(hit_word(7'd0, 7'd0, 7'd1, 6'd1, 3'd4));
        foreach (words[i]) begin
            send_word(words[i]);
        end
    endtask

    initial begin
        sb           = new();
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        send_idle    = 28;
        recv_idle    = 45;
        hold_req     = 0;
        hold_left    = 0;
        cycle_count  = 0;
        settings_run = 1;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        run_directed();
        drain();

        set_health(FE_A, 4'd2);
        run_random(130);
        drain();

        send_idle = 45;
        recv_idle = 28;
        set_health(4'd15, 4'd0);
        run_random(130);
        drain();

        send_idle = 0;
        recv_idle = 0;
        set_health(FE_D, 4'd5);
        run_random(100);
        drain();

        set_health(4'd0, 4'd15);
        @(posedge aclk);
        hold_req = 1;
        run_random(40);
        drain();

        $display("%0d words sent, %0d hits checked (%0d noisy) over %0d health settings",
                 sb.words_seen, sb.hits_checked, sb.noisy_seen, settings_run);
        $display("idling on both sides, back-to-back traffic and one long output hold");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d hits never seen", sb.errors, sb.pending());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[readout_word_hit_decoder_unit.f]
+incdir+hw/rtl
hw/rtl/rwhd_pkg.sv
hw/rtl/rwhd_decode.sv
hw/rtl/readout_word_hit_decoder_unit.sv
test/readout_word_hit_decoder_unit_test.sv
